// ===== rtl/hkb_pkg.sv =====
// hkb_pkg: shared constants, types and keymap for the keyboard report builder
package hkb_pkg;

  // default sizes
  localparam int BITSET_BYTES_DEF   = 29;
  localparam int BOOT_KEY_SLOTS_DEF = 6;

  // bitset memory address width (bitset depth ranges 29..32)
  localparam int ADDR_W   = 5;
  localparam int PADDR_W  = 6;
  localparam int PDATA_W  = 64;
  localparam int FKMASK_W = 232;

  // report layout
  localparam logic [4:0] REPORT_LEN = 5'd29;
  localparam logic [4:0] MOD_BYTE   = 5'd28;

  // usage codes
  localparam logic [7:0] USAGE_LIMIT   = 8'hE8;
  localparam logic [7:0] MOD_FIRST     = 8'hE0;
  localparam logic [7:0] MOD_LAST      = 8'hE7;
  localparam logic [7:0] BOOT_FIRST    = 8'h04;
  localparam logic [7:0] BOOT_LAST     = 8'hDF;
  localparam logic [7:0] ROLLOVER      = 8'h01;
  localparam logic [7:0] CONSUMER_PAGE = 8'h10;

  // input modes
  localparam logic [1:0] MODE_KEY     = 2'd0;
  localparam logic [1:0] MODE_RESEND  = 2'd1;
  localparam logic [1:0] MODE_SUSPEND = 2'd2;
  localparam logic [1:0] MODE_WAKE    = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_KEYBOARD = 2'd0;
  localparam logic [1:0] KIND_FUNCKEY  = 2'd1;
  localparam logic [1:0] KIND_CONSUMER = 2'd2;

  // register indexes
  localparam logic [2:0] REG_PROTOCOL = 3'd0;
  localparam logic [2:0] REG_FKMASK0  = 3'd1;
  localparam logic [2:0] REG_FKMASK1  = 3'd2;
  localparam logic [2:0] REG_FKMASK2  = 3'd3;
  localparam logic [2:0] REG_FKMASK3  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT
  } state_t;

  // configuration seen by the control logic
  typedef struct packed {
    logic                report_protocol;
    logic [FKMASK_W-1:0] fkmask;
  } cfg_t;

  // boot slot collector control
  typedef struct packed {
    logic       clear;
    logic       take;
    logic [4:0] base;
    logic [7:0] data;
  } scan_t;

  // bitset memory request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // 6x4 matrix keymap, zero for unmapped positions
  function automatic logic [15:0] matrix_code(input logic [2:0] row, input logic [2:0] col);
    logic [15:0] code;
    case ({row, col})
      6'o03:   code = 16'h10E2;
      6'o10:   code = 16'h0053;
      6'o11:   code = 16'h0055;
      6'o12:   code = 16'h0054;
      6'o13:   code = 16'h0056;
      6'o20:   code = 16'h005F;
      6'o21:   code = 16'h0060;
      6'o22:   code = 16'h0061;
      6'o30:   code = 16'h005C;
      6'o31:   code = 16'h005D;
      6'o32:   code = 16'h005E;
      6'o33:   code = 16'h0057;
      6'o40:   code = 16'h0059;
      6'o41:   code = 16'h005A;
      6'o42:   code = 16'h005B;
      6'o50:   code = 16'h0062;
      6'o51:   code = 16'h0063;
      6'o53:   code = 16'h0058;
      default: code = 16'h0000;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/hkb_ram.sv =====
// hkb_ram: generic single-write single-read ram with registered read
module hkb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/hkb_cfg.sv =====
// hkb_cfg: apb register file for protocol select and function-key masks
module hkb_cfg
  import hkb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic        report_protocol;
  logic [63:0] fkmask0;
  logic [63:0] fkmask1;
  logic [63:0] fkmask2;
  logic [39:0] fkmask3;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      report_protocol <= 1'b1;
      fkmask0         <= '0;
      fkmask1         <= '0;
      fkmask2         <= '0;
      fkmask3         <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PROTOCOL: report_protocol <= pwdata[0];
        REG_FKMASK0:  fkmask0         <= pwdata;
        REG_FKMASK1:  fkmask1         <= pwdata;
        REG_FKMASK2:  fkmask2         <= pwdata;
        REG_FKMASK3:  fkmask3         <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_PROTOCOL: prdata = {63'd0, report_protocol};
      REG_FKMASK0:  prdata = fkmask0;
      REG_FKMASK1:  prdata = fkmask1;
      REG_FKMASK2:  prdata = fkmask2;
      REG_FKMASK3:  prdata = {24'd0, fkmask3};
      default:      prdata = '0;
    endcase
  end

  assign cfg.report_protocol = report_protocol;
  assign cfg.fkmask          = {fkmask3, fkmask2, fkmask1, fkmask0};

endmodule

// ===== rtl/hkb_slots.sv =====
// hkb_slots: collects the lowest pressed usages for the boot report
module hkb_slots
  import hkb_pkg::*;
#(
  parameter int BOOT_KEY_SLOTS = BOOT_KEY_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  scan_t                          scan,
  output logic [BOOT_KEY_SLOTS-1:0][7:0] slots
);

  localparam int NW = $clog2(BOOT_KEY_SLOTS + 1);

  logic [BOOT_KEY_SLOTS-1:0][7:0] slots_next;
  logic [NW-1:0]                  nfill;
  logic [NW-1:0]                  nfill_next;
  logic [7:0]                     u;

  // place the set bits of one bitset byte, lowest usage first
  always_comb begin
    slots_next = slots;
    nfill_next = nfill;
    u          = '0;
    for (int j = 0; j < 8; j++) begin
      u = {scan.base, 3'(j)};
      if (scan.data[j] && (u >= BOOT_FIRST) && (u <= BOOT_LAST) &&
          (nfill_next < NW'(BOOT_KEY_SLOTS))) begin
        for (int i = 0; i < BOOT_KEY_SLOTS; i++) begin
          if (nfill_next == NW'(i)) begin
            slots_next[i] = u;
          end
        end
        nfill_next = nfill_next + NW'(1);
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst || scan.clear) begin
      nfill <= '0;
    end else if (scan.take) begin
      nfill <= nfill_next;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (scan.clear) begin
      slots <= '0;
    end else if (scan.take) begin
      slots <= slots_next;
    end
  end

endmodule

// ===== rtl/hkb_ctrl.sv =====
// hkb_ctrl: event sequencer, bitset read-modify-write and report beat streaming
module hkb_ctrl
  import hkb_pkg::*;
#(
  parameter int BITSET_BYTES   = BITSET_BYTES_DEF,
  parameter int BOOT_KEY_SLOTS = BOOT_KEY_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     mode,
  input  logic [2:0]                     key_row,
  input  logic [2:0]                     key_col,
  input  logic                           key_pressed,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     result_kind,
  output logic [7:0]                     byte_value,
  output logic [4:0]                     byte_index,
  output logic                           last_byte,
  // configuration
  input  cfg_t                           cfg,
  // bitset memory
  output ram_req_t                       ram_req,
  input  logic [7:0]                     ram_rdata,
  // boot slot collector
  output scan_t                          scan,
  input  logic [BOOT_KEY_SLOTS-1:0][7:0] slots
);

  state_t                  state, state_next;
  logic                    susp, susp_next;
  logic [7:0]              cnt, cnt_next;
  logic [BITSET_BYTES-1:0] vld, vld_next;
  logic [7:0]              usage, usage_next;
  logic                    press, press_next;
  logic [1:0]              kind, kind_next;
  logic [4:0]              beat, beat_next;
  logic                    boot, boot_next;
  logic [4:0]              sc, sc_next;
  logic                    scan_pend, scan_pend_next;
  logic [4:0]              scan_base, scan_base_next;
  logic                    rd_ent_vld;
  // read stage ahead of the output register
  logic                    s1_valid, s1_valid_next;
  logic                    s1_from_ram, s1_from_ram_next;
  logic [7:0]              s1_byte, s1_byte_next;
  logic [4:0]              s1_idx, s1_idx_next;
  logic [1:0]              s1_kind, s1_kind_next;
  logic                    s1_last, s1_last_next;

  logic        move;
  logic        free;
  logic [7:0]  rd_byte;
  logic [7:0]  s1_value;
  logic [15:0] code;
  logic [7:0]  wmask;
  logic        changed;
  logic [4:0]  nbeats;
  logic [7:0]  slot_val;

  // stage hand-off
  assign move     = s1_valid && (!out_valid || !out_stall);
  assign free     = !s1_valid || move;
  assign rd_byte  = rd_ent_vld ? ram_rdata : 8'd0;
  assign s1_value = s1_from_ram ? rd_byte : s1_byte;
  assign code     = matrix_code(key_row, key_col);
  assign wmask    = 8'd1 << usage[2:0];
  assign changed  = (usage < USAGE_LIMIT) && (rd_byte[usage[2:0]] != press);
  assign nbeats   = boot ? 5'(2 + BOOT_KEY_SLOTS) : REPORT_LEN;

  // boot slot value for the current beat
  always_comb begin
    slot_val = 8'd0;
    if (cnt > 8'(BOOT_KEY_SLOTS)) begin
      slot_val = ROLLOVER;
    end else if (cnt != 8'd0) begin
      for (int i = 0; i < BOOT_KEY_SLOTS; i++) begin
        if (beat == 5'(i + 2)) begin
          slot_val = slots[i];
        end
      end
    end
  end

  // next state and control
  always_comb begin
    state_next       = state;
    susp_next        = susp;
    cnt_next         = cnt;
    vld_next         = vld;
    usage_next       = usage;
    press_next       = press;
    kind_next        = kind;
    beat_next        = beat;
    boot_next        = boot;
    sc_next          = sc;
    scan_pend_next   = 1'b0;
    scan_base_next   = scan_base;
    s1_valid_next    = move ? 1'b0 : s1_valid;
    s1_from_ram_next = s1_from_ram;
    s1_byte_next     = s1_byte;
    s1_idx_next      = s1_idx;
    s1_kind_next     = s1_kind;
    s1_last_next     = s1_last;
    ram_req          = '0;
    in_stall         = 1'b1;
    scan.clear       = 1'b0;
    scan.take        = scan_pend;
    scan.base        = scan_base;
    scan.data        = rd_byte;

    case (state)
      ST_IDLE: begin
        in_stall = s1_valid;
        if (in_valid && !s1_valid) begin
          case (mode)
            MODE_SUSPEND: begin
              susp_next = 1'b1;
            end
            MODE_WAKE: begin
              susp_next = 1'b0;
              cnt_next  = '0;
              vld_next  = '0;
            end
            MODE_RESEND: begin
              if (!susp) begin
                kind_next = KIND_KEYBOARD;
                beat_next = '0;
                sc_next   = '0;
                boot_next = !cfg.report_protocol;
                state_next = cfg.report_protocol ? ST_EMIT : ST_SCAN;
              end
            end
            MODE_KEY: begin
              if (!susp && code != 16'd0) begin
                if (code[15:8] == CONSUMER_PAGE) begin
                  // consumer usage goes out as a single beat
                  s1_valid_next    = 1'b1;
                  s1_from_ram_next = 1'b0;
                  s1_byte_next     = key_pressed ? code[7:0] : 8'd0;
                  s1_idx_next      = '0;
                  s1_kind_next     = KIND_CONSUMER;
                  s1_last_next     = 1'b1;
                end else begin
                  usage_next    = code[7:0];
                  press_next    = key_pressed;
                  ram_req.re    = 1'b1;
                  ram_req.raddr = code[7:3];
                  state_next    = ST_RMW;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_RMW: begin
        if (changed) begin
          ram_req.we              = 1'b1;
          ram_req.waddr           = usage[7:3];
          ram_req.wdata           = press ? (rd_byte | wmask) : (rd_byte & ~wmask);
          vld_next[usage[7:3]]    = 1'b1;
          if (!(usage inside {[MOD_FIRST:MOD_LAST]})) begin
            cnt_next = press ? cnt + 8'd1 : cnt - 8'd1;
          end
          beat_next = '0;
          sc_next   = '0;
          if (cfg.fkmask[usage]) begin
            kind_next  = KIND_FUNCKEY;
            boot_next  = 1'b0;
            state_next = ST_EMIT;
          end else begin
            kind_next  = KIND_KEYBOARD;
            boot_next  = !cfg.report_protocol;
            state_next = cfg.report_protocol ? ST_EMIT : ST_SCAN;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // sweep the key bytes into the slot collector
        ram_req.re     = 1'b1;
        ram_req.raddr  = sc;
        scan.clear     = (sc == 5'd0);
        scan_pend_next = 1'b1;
        scan_base_next = sc;
        sc_next        = sc + 5'd1;
        if (sc == MOD_BYTE - 5'd1) begin
          state_next = ST_SCAN_END;
        end
      end

      ST_SCAN_END: begin
        beat_next  = '0;
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (free) begin
          s1_valid_next = 1'b1;
          s1_idx_next   = beat;
          s1_kind_next  = kind;
          s1_last_next  = (beat == nbeats - 5'd1);
          if (!boot || beat == 5'd0) begin
            ram_req.re       = 1'b1;
            ram_req.raddr    = (beat == 5'd0) ? MOD_BYTE : beat - 5'd1;
            s1_from_ram_next = 1'b1;
          end else begin
            s1_from_ram_next = 1'b0;
            s1_byte_next     = (beat == 5'd1) ? 8'd0 : slot_val;
          end
          beat_next = beat + 5'd1;
          if (beat == nbeats - 5'd1) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      susp      <= 1'b0;
      cnt       <= '0;
      vld       <= '0;
      s1_valid  <= 1'b0;
      scan_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      susp      <= susp_next;
      cnt       <= cnt_next;
      vld       <= vld_next;
      s1_valid  <= s1_valid_next;
      scan_pend <= scan_pend_next;
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    usage       <= usage_next;
    press       <= press_next;
    kind        <= kind_next;
    beat        <= beat_next;
    boot        <= boot_next;
    sc          <= sc_next;
    scan_base   <= scan_base_next;
    s1_from_ram <= s1_from_ram_next;
    s1_byte     <= s1_byte_next;
    s1_idx      <= s1_idx_next;
    s1_kind     <= s1_kind_next;
    s1_last     <= s1_last_next;
    if (ram_req.re) begin
      rd_ent_vld <= vld[ram_req.raddr];
    end
    if (move) begin
      result_kind <= s1_kind;
      byte_value  <= s1_value;
      byte_index  <= s1_idx;
      last_byte   <= s1_last;
    end
  end

endmodule

// ===== rtl/hid_keyboard_report_builder.sv =====
// hid_keyboard_report_builder: top level of the keyboard report builder
//
// Key events (mode, key_row, key_col, key_pressed) come in on a valid/stall
// channel; report bytes leave one per beat on a valid/stall channel with
// result_kind, byte_value, byte_index and last_byte, last_byte marking the
// final beat of an event. An APB port at byte address 8*i holds the protocol
// select and the function-key masks; pready is always high.
// The block takes one event at a time. Suspend, wake, unmapped and suspended
// events are done in the idle state; a consumer event passes through the read
// stage, and a mapped key found unchanged goes back to idle from the RMW state.
// A key change costs a read-modify-write of the bitset memory, then an NKRO or
// function-key report streams its 29 bytes out of the single read port at one
// beat a cycle while the receiver does not stall. A boot report first sweeps
// the 28 key bytes through the same port, then sends 2+BOOT_KEY_SLOTS beats.
// Reset clears the bitset at once through per-byte valid bits, clears the
// key count and suspend flag and selects NKRO. When the receiver stalls,
// the output register holds its beat and the stream pauses; the next event
// is taken once the last beat has left the read stage.
module hid_keyboard_report_builder
  import hkb_pkg::*;
#(
  parameter int BITSET_BYTES   = BITSET_BYTES_DEF,
  parameter int BOOT_KEY_SLOTS = BOOT_KEY_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [2:0]         key_row,
  input  logic [2:0]         key_col,
  input  logic               key_pressed,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         result_kind,
  output logic [7:0]         byte_value,
  output logic [4:0]         byte_index,
  output logic               last_byte
);

  cfg_t                           cfg;
  ram_req_t                       ram_req;
  logic [7:0]                     ram_rdata;
  scan_t                          scan;
  logic [BOOT_KEY_SLOTS-1:0][7:0] slots;

  // configuration registers
  hkb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // key bitset memory
  hkb_ram #(
    .WIDTH (8),
    .DEPTH (BITSET_BYTES)
  ) u_bitset (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // boot report slot collector
  hkb_slots #(
    .BOOT_KEY_SLOTS (BOOT_KEY_SLOTS)
  ) u_slots (
    .clk   (clk),
    .rst   (rst),
    .scan  (scan),
    .slots (slots)
  );

  // sequencer and output stage
  hkb_ctrl #(
    .BITSET_BYTES   (BITSET_BYTES),
    .BOOT_KEY_SLOTS (BOOT_KEY_SLOTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .key_row     (key_row),
    .key_col     (key_col),
    .key_pressed (key_pressed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .byte_value  (byte_value),
    .byte_index  (byte_index),
    .last_byte   (last_byte),
    .cfg         (cfg),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .scan        (scan),
    .slots       (slots)
  );

  // a consumer beat is always a lone final beat at index zero
  a_consumer_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_CONSUMER |-> byte_index == 5'd0 && last_byte)
    else $error("consumer beat not a single final beat");

  // only the final byte of a report may sit at the top index
  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_byte |-> byte_index != MOD_BYTE)
    else $error("report runs past its last byte");

  // keyboard reports end at the boot or nkro length
  a_kbd_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte && result_kind == KIND_KEYBOARD
      |-> byte_index == MOD_BYTE || byte_index == 5'(BOOT_KEY_SLOTS + 1))
    else $error("keyboard report has a wrong length");

  // function-key reports always carry the full bitmap
  a_fk_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte && result_kind == KIND_FUNCKEY |-> byte_index == MOD_BYTE)
    else $error("function-key report has a wrong length");

endmodule

// ===== tb/keyboard_report_checker.sv =====
// keyboard_report_checker: predicts report beats from accepted events and compares the output
`timescale 1ns / 100ps

module keyboard_report_checker
  import hkb_pkg::*;
#(
  parameter int SLOT_COUNT = BOOT_KEY_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  // input channel
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [2:0]         key_row,
  input  logic [2:0]         key_col,
  input  logic               key_pressed,
  // output channel
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         result_kind,
  input  logic [7:0]         byte_value,
  input  logic [4:0]         byte_index,
  input  logic               last_byte,
  // status toward the top
  output int                 mismatches,
  output int                 pending,
  output int                 beats_checked
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [4:0] index;
    logic       last;
  } report_beat_t;

  // usage per matrix position, row*4+col; consumer page in the high byte
  localparam logic [0:23][15:0] MATRIX_CODES = {
    16'h0000, 16'h0000, 16'h0000, 16'h10E2,
    16'h0053, 16'h0055, 16'h0054, 16'h0056,
    16'h005F, 16'h0060, 16'h0061, 16'h0000,
    16'h005C, 16'h005D, 16'h005E, 16'h0057,
    16'h0059, 16'h005A, 16'h005B, 16'h0000,
    16'h0062, 16'h0063, 16'h0000, 16'h0058
  };

  localparam int MOD_POS = 8 * int'(MOD_BYTE);

  // predicted block state
  logic [8*BITSET_BYTES_DEF-1:0] held_keys;
  logic [7:0]                    key_total;
  logic                          asleep;
  logic                          nkro_on;
  logic [FKMASK_W-1:0]           fn_marks;
  report_beat_t                  report_queue[$];

  initial begin
    mismatches    = 0;
    beats_checked = 0;
    pending       = 0;
  end

  task automatic queue_beat(input logic [1:0] kind, input logic [7:0] value, input int index,
                            input logic last);
    report_beat_t b;
    b.kind  = kind;
    b.value = value;
    b.index = index[4:0];
    b.last  = last;
    report_queue.push_back(b);
  endtask

  // nkro or function-key layout: modifiers, then key bytes 0..27
  task automatic queue_bitmap(input logic [1:0] kind);
    queue_beat(kind, held_keys[MOD_POS +: 8], 0, 1'b0);
    for (int b = 1; b < int'(REPORT_LEN); b++)
      queue_beat(kind, held_keys[8*(b-1) +: 8], b, b == int'(REPORT_LEN) - 1);
  endtask

  // boot layout: modifiers, reserved zero, lowest held usages or rollover
  task automatic queue_boot();
    logic [7:0] slots [SLOT_COUNT];
    int         n;
    n = 0;
    for (int s = 0; s < SLOT_COUNT; s++)
      slots[s] = (key_total > SLOT_COUNT) ? ROLLOVER : 8'h00;
    if (key_total != 0 && key_total <= SLOT_COUNT) begin
      for (int u = int'(BOOT_FIRST); u <= int'(BOOT_LAST) && n < SLOT_COUNT; u++)
        if (held_keys[u]) begin
          slots[n] = u[7:0];
          n++;
        end
    end
    queue_beat(KIND_KEYBOARD, held_keys[MOD_POS +: 8], 0, 1'b0);
    queue_beat(KIND_KEYBOARD, 8'h00, 1, 1'b0);
    for (int s = 0; s < SLOT_COUNT; s++)
      queue_beat(KIND_KEYBOARD, slots[s], 2 + s, s == SLOT_COUNT - 1);
  endtask

  task automatic queue_report();
    if (nkro_on)
      queue_bitmap(KIND_KEYBOARD);
    else
      queue_boot();
  endtask

  // set or clear one usage; changed only on a real transition
  task automatic apply_key(input logic [7:0] usage, input logic press, output logic changed);
    changed = 1'b0;
    if (usage < USAGE_LIMIT && held_keys[usage] != press) begin
      held_keys[usage] = press;
      changed = 1'b1;
      if (usage < MOD_FIRST || usage > MOD_LAST)
        key_total = press ? key_total + 8'd1 : key_total - 8'd1;
    end
  endtask

  task automatic predict_event(input logic [1:0] m, input logic [2:0] row, input logic [2:0] col,
                               input logic press);
    logic [15:0] code;
    logic        changed;
    code = 16'h0000;
    if (row < 3'd6 && col < 3'd4)
      code = MATRIX_CODES[{row, col[1:0]}];
    case (m)
      MODE_SUSPEND: asleep = 1'b1;
      MODE_WAKE: begin
        asleep    = 1'b0;
        held_keys = '0;
        key_total = '0;
      end
      MODE_RESEND: begin
        if (!asleep)
          queue_report();
      end
      default: begin
        if (!asleep && code != 16'h0000) begin
          if (code[15:8] == CONSUMER_PAGE) begin
            queue_beat(KIND_CONSUMER, press ? code[7:0] : 8'h00, 0, 1'b1);
          end else begin
            apply_key(code[7:0], press, changed);
            if (changed && fn_marks[code[7:0]])
              queue_bitmap(KIND_FUNCKEY);
            else if (changed)
              queue_report();
          end
        end
      end
    endcase
  endtask

  task automatic apply_write(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
    case (idx)
      REG_PROTOCOL: nkro_on = value[0];
      REG_FKMASK0:  fn_marks[63:0]    = value;
      REG_FKMASK1:  fn_marks[127:64]  = value;
      REG_FKMASK2:  fn_marks[191:128] = value;
      REG_FKMASK3:  fn_marks[231:192] = value[39:0];
      default: ;
    endcase
  endtask

  task automatic check_beat();
    report_beat_t got;
    report_beat_t want;
    got = {result_kind, byte_value, byte_index, last_byte};
    beats_checked++;
    if (report_queue.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected beat kind %0d value %02h index %0d last %0b",
               $time, got.kind, got.value, got.index, got.last);
    end else begin
      want = report_queue.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: beat mismatch, expected kind %0d value %02h index %0d last %0b",
                 $time, want.kind, want.value, want.index, want.last);
        $display("%0t:                  actual kind %0d value %02h index %0d last %0b",
                 $time, got.kind, got.value, got.index, got.last);
      end
    end
  endtask

  // register writes, accepted events and output beats, all at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      held_keys = '0;
      key_total = '0;
      asleep    = 1'b0;
      nkro_on   = 1'b1;
      fn_marks  = '0;
      report_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        apply_write(paddr[5:3], pwdata);
      if (in_valid && !in_stall)
        predict_event(mode, key_row, key_col, key_pressed);
      if (out_valid && !out_stall)
        check_beat();
    end
    pending = report_queue.size();
  end

endmodule

// ===== tb/hid_keyboard_report_builder_tb.sv =====
// hid_keyboard_report_builder_tb: clock, reset, stimulus and verdict for the report builder
`timescale 1ns / 100ps

module hid_keyboard_report_builder_tb
  import hkb_pkg::*;
();

  // matrix positions that map to a usage, {row, col}
  localparam logic [0:17][5:0] LIVE_KEYS = {
    6'o03, 6'o10, 6'o11, 6'o12, 6'o13, 6'o20, 6'o21, 6'o22, 6'o30,
    6'o31, 6'o32, 6'o33, 6'o40, 6'o41, 6'o42, 6'o50, 6'o51, 6'o53
  };

  localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HIGH_MASK = 64'h0000_00FF_FFFF_FFFF;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         mode;
  logic [2:0]         key_row;
  logic [2:0]         key_col;
  logic               key_pressed;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         result_kind;
  logic [7:0]         byte_value;
  logic [4:0]         byte_index;
  logic               last_byte;

  int   mismatches;
  int   pending;
  int   beats_checked;
  int   idle_pct;
  int   stall_pct;
  int   events_sent;
  logic asleep;

  hid_keyboard_report_builder dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .key_row    (key_row),
    .key_col    (key_col),
    .key_pressed(key_pressed),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_kind(result_kind),
    .byte_value (byte_value),
    .byte_index (byte_index),
    .last_byte  (last_byte)
  );

  keyboard_report_checker report_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .key_row      (key_row),
    .key_col      (key_col),
    .key_pressed  (key_pressed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .byte_value   (byte_value),
    .byte_index   (byte_index),
    .last_byte    (last_byte),
    .mismatches   (mismatches),
    .pending      (pending),
    .beats_checked(beats_checked)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // one event beat, with random gaps ahead of it
  task automatic send_event(input logic [1:0] m, input logic [2:0] row, input logic [2:0] col,
                            input logic press);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    key_row     <= row;
    key_col     <= col;
    key_pressed <= press;
    do @(posedge clk); while (in_stall);
  endtask

  // setup then access phase
  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold off until every predicted beat is out, then let the block go idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // mostly mapped key changes, some noise, resends and short sleeps
  task automatic random_event();
    int         pick;
    logic [5:0] pos;
    logic [1:0] m;
    logic [2:0] row;
    logic [2:0] col;
    logic       press;
    pick  = $urandom_range(99);
    pos   = LIVE_KEYS[$urandom_range(17)];
    m     = MODE_KEY;
    row   = pos[5:3];
    col   = pos[2:0];
    press = ($urandom_range(99) < 45);
    if (asleep) begin
      if (pick < 45) begin
        m = MODE_WAKE;
        asleep = 1'b0;
      end else begin
        m   = 2'($urandom_range(2));
        row = 3'($urandom_range(7));
        col = 3'($urandom_range(7));
      end
      send_event(m, row, col, press);
    end else begin
      if (pick >= 72 && pick < 82) begin
        row   = 3'($urandom_range(7));
        col   = 3'($urandom_range(7));
        press = 1'($urandom_range(1));
      end else if (pick >= 82 && pick < 92) begin
        m = MODE_RESEND;
      end else if (pick >= 92 && pick < 97) begin
        m = MODE_SUSPEND;
        asleep = 1'b1;
      end else if (pick >= 97) begin
        m = MODE_WAKE;
      end
      send_event(m, row, col, press);
    end
    events_sent++;
    if (events_sent % 30 == 0)
      settle();
  endtask

  task automatic run_random(input int count);
    int target;
    target = events_sent + count;
    while (events_sent < target)
      random_event();
  endtask

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    mode        = MODE_KEY;
    key_row     = 3'd0;
    key_col     = 3'd0;
    key_pressed = 1'b0;
    out_stall   = 1'b0;
    asleep      = 1'b0;
    events_sent = 0;
    idle_pct    = 11;
    stall_pct   = 62;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // nkro, no function keys
    write_reg(REG_PROTOCOL, 64'd1);
    write_reg(REG_FKMASK0, '0);
    write_reg(REG_FKMASK1, '0);
    write_reg(REG_FKMASK2, '0);
    write_reg(REG_FKMASK3, '0);
    send_event(MODE_RESEND, 3'd0, 3'd0, 1'b0);
    send_event(MODE_KEY, 3'd0, 3'd3, 1'b1);
    send_event(MODE_KEY, 3'd0, 3'd3, 1'b0);
    send_event(MODE_KEY, 3'd1, 3'd0, 1'b1);
    // repeated press, unmapped positions, repeated release
    send_event(MODE_KEY, 3'd1, 3'd0, 1'b1);
    send_event(MODE_KEY, 3'd7, 3'd7, 1'b1);
    send_event(MODE_KEY, 3'd0, 3'd0, 1'b1);
    send_event(MODE_KEY, 3'd1, 3'd0, 1'b0);
    send_event(MODE_KEY, 3'd1, 3'd0, 1'b0);
    send_event(MODE_KEY, 3'd1, 3'd1, 1'b1);
    // sleep drops events and resends, wake clears the held key
    send_event(MODE_SUSPEND, 3'd0, 3'd0, 1'b0);
    send_event(MODE_KEY, 3'd1, 3'd2, 1'b1);
    send_event(MODE_RESEND, 3'd0, 3'd0, 1'b0);
    send_event(MODE_SUSPEND, 3'd0, 3'd0, 1'b0);
    send_event(MODE_WAKE, 3'd0, 3'd0, 1'b0);
    send_event(MODE_RESEND, 3'd0, 3'd0, 1'b0);
    settle();

    // boot protocol: empty, filling the slots, then rollover
    write_reg(REG_PROTOCOL, 64'd0);
    send_event(MODE_RESEND, 3'd0, 3'd0, 1'b0);
    send_event(MODE_KEY, 3'd1, 3'd0, 1'b1);
    send_event(MODE_KEY, 3'd1, 3'd1, 1'b1);
    send_event(MODE_KEY, 3'd1, 3'd2, 1'b1);
    send_event(MODE_KEY, 3'd1, 3'd3, 1'b1);
    send_event(MODE_KEY, 3'd2, 3'd0, 1'b1);
    send_event(MODE_KEY, 3'd2, 3'd1, 1'b1);
    send_event(MODE_KEY, 3'd2, 3'd2, 1'b1);
    send_event(MODE_RESEND, 3'd0, 3'd0, 1'b0);
    run_random(30);
    settle();

    // receiver fast, sender slow; boot with mixed function keys
    idle_pct  = 62;
    stall_pct = 11;
    write_reg(REG_FKMASK0, {$urandom, $urandom});
    write_reg(REG_FKMASK1, {$urandom, $urandom});
    write_reg(REG_FKMASK2, {$urandom, $urandom});
    write_reg(REG_FKMASK3, {$urandom, $urandom} & HIGH_MASK);
    run_random(35);
    settle();

    // back to back; nkro with every usage a function key, then mixed
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(REG_PROTOCOL, 64'd1);
    write_reg(REG_FKMASK0, ALL_ONES);
    write_reg(REG_FKMASK1, ALL_ONES);
    write_reg(REG_FKMASK2, ALL_ONES);
    write_reg(REG_FKMASK3, HIGH_MASK);
    run_random(15);
    settle();
    write_reg(REG_FKMASK1, {$urandom, $urandom});
    run_random(20);
    settle();

    $display("covered %0d random events plus directed ones over three handshake patterns",
             events_sent);
    $display("%0d report beats compared, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
